// ===== sv/swm_pkg.sv =====
// Shared constants and controller/datapath signal groups for the sliding window maximum block.
package swm_pkg;

  localparam int DATA_W         = 32;
  localparam int WLEN_W         = 11;
  localparam int MAX_WINDOW_DEF = 1024;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // latch the incoming word and apply restart
    logic rd_front;   // read the oldest candidate
    logic drop_front; // drop the oldest candidate
    logic rd_back;    // read the newest candidate
    logic drop_back;  // drop the newest candidate
    logic append;     // write the new sample at the back
    logic rd_head;    // read the current maximum
    logic load_out;   // move the result into the output register
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;      // no candidates held
    logic front_old;  // oldest candidate has left the window
    logic back_le;    // newest candidate is not greater than the sample
    logic emit;       // this sample completes a window
    logic out_free;   // output register can take a result this cycle
  } ctl_stat_t;

endpackage

// ===== sv/swm_if.sv =====
// Valid/ready channel interfaces for samples, results and the window length register.
interface swm_sample_if import swm_pkg::*;;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] sample;
  logic              restart;

  modport source (output valid, output sample, output restart, input ready);
  modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface swm_result_if import swm_pkg::*;;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] window_max;
  logic [DATA_W-1:0] window_start;

  modport source (output valid, output window_max, output window_start, input ready);
  modport sink   (input valid, input window_max, input window_start, output ready);
endinterface

interface swm_cfg_if import swm_pkg::*;;
  logic              valid;
  logic              ready;
  logic [WLEN_W-1:0] window_len;

  modport source (output valid, output window_len, input ready);
  modport sink   (input valid, input window_len, output ready);
endinterface

// ===== sv/swm_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
module swm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/swm_ctrl.sv =====
// Controller state machine that sequences eviction, back drops, append and result output.
module swm_ctrl import swm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  ctl_stat_t stat,
  output ctl_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EV_RD  = 3'd1;
  localparam logic [2:0] S_EV_CHK = 3'd2;
  localparam logic [2:0] S_BK_RD  = 3'd3;
  localparam logic [2:0] S_BK_CHK = 3'd4;
  localparam logic [2:0] S_APPEND = 3'd5;
  localparam logic [2:0] S_HD_RD  = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_EV_RD;
        end
      end
      S_EV_RD: begin
        if (stat.empty) begin
          state_next = S_BK_RD;
        end else begin
          cmd.rd_front = 1'b1;
          state_next   = S_EV_CHK;
        end
      end
      S_EV_CHK: begin
        if (stat.front_old) begin
          cmd.drop_front = 1'b1;
          state_next     = S_EV_RD;
        end else begin
          state_next = S_BK_RD;
        end
      end
      S_BK_RD: begin
        if (stat.empty) begin
          state_next = S_APPEND;
        end else begin
          cmd.rd_back = 1'b1;
          state_next  = S_BK_CHK;
        end
      end
      S_BK_CHK: begin
        if (stat.back_le) begin
          cmd.drop_back = 1'b1;
          state_next    = S_BK_RD;
        end else begin
          state_next = S_APPEND;
        end
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        state_next = S_HD_RD;
      end
      S_HD_RD: begin
        cmd.rd_head = 1'b1;
        state_next  = S_OUT;
      end
      S_OUT: begin
        // A sample that completes no window leaves without a result.
        if (!stat.emit) begin
          state_next = S_IDLE;
        end else if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_drop_front_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.drop_front |-> !stat.empty)
    else $error("front pop issued on an empty deque");

  a_drop_back_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.drop_back |-> !stat.empty)
    else $error("back pop issued on an empty deque");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (stat.out_free && stat.emit))
    else $error("result loaded while the output register was occupied");

  a_append_fills: assert property (@(posedge clk) disable iff (rst)
    cmd.append |=> !stat.empty)
    else $error("deque empty after an append");

endmodule

// ===== sv/swm_dp.sv =====
// Datapath: deque storage, pointers, position counter, window register and output register.
module swm_dp import swm_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [DATA_W-1:0]   sample,
  input  logic                restart,
  swm_cfg_if.sink             cfg,
  swm_result_if.source        results,
  input  ctl_cmd_t            cmd,
  output ctl_stat_t           stat
);

  localparam int AW = $clog2(MAX_WINDOW);
  localparam int CW = $clog2(MAX_WINDOW + 1);

  logic [WLEN_W-1:0] window_len;
  logic [WLEN_W-1:0] w_eff;
  logic [WLEN_W-1:0] w_cur;
  logic [AW-1:0]     head;
  logic [CW-1:0]     count;
  logic [DATA_W-1:0] pos;
  logic [DATA_W-1:0] p_cur;
  logic              wrapped;
  logic [DATA_W-1:0] samp;
  logic [DATA_W-1:0] val_rd;
  logic [DATA_W-1:0] pos_rd;
  logic [AW-1:0]     head_inc;
  logic [AW-1:0]     back_slot;
  logic [AW-1:0]     tail_slot;
  logic              full;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;
  logic              rd_en;
  logic              out_valid;
  logic [DATA_W-1:0] out_max;
  logic [DATA_W-1:0] out_start;

  // Circular index: the sum stays below twice the depth, so one subtract wraps it.
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [CW:0]   off);
    logic [CW:0] s;
    s = (CW+1)'(base) + off;
    if (s >= (CW+1)'(MAX_WINDOW)) begin
      s = s - (CW+1)'(MAX_WINDOW);
    end
    return AW'(s);
  endfunction

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= WLEN_W'(1);
    end else if (cfg.valid) begin
      window_len <= cfg.window_len;
    end
  end

  always_comb begin
    w_eff = window_len;
    if (window_len == '0) begin
      w_eff = WLEN_W'(1);
    end else if (32'(window_len) > 32'(MAX_WINDOW)) begin
      w_eff = WLEN_W'(MAX_WINDOW);
    end
  end

  assign head_inc  = wrap_add(head, (CW+1)'(1));
  assign back_slot = wrap_add(head, (CW+1)'(count) - (CW+1)'(1));
  assign tail_slot = wrap_add(head, (CW+1)'(count));
  assign full      = (count == CW'(MAX_WINDOW));
  // With a full deque the oldest entry gives way, and its slot takes the new sample.
  assign wr_addr   = full ? head : tail_slot;
  assign rd_en     = cmd.rd_front || cmd.rd_back || cmd.rd_head;
  assign rd_addr   = cmd.rd_back ? back_slot : head;

  swm_ram #(.WIDTH(DATA_W), .DEPTH(MAX_WINDOW)) u_val_ram (
    .clk   (clk),
    .we    (cmd.append),
    .waddr (wr_addr),
    .wdata (samp),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (val_rd)
  );

  swm_ram #(.WIDTH(DATA_W), .DEPTH(MAX_WINDOW)) u_pos_ram (
    .clk   (clk),
    .we    (cmd.append),
    .waddr (wr_addr),
    .wdata (p_cur),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (pos_rd)
  );

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      samp  <= sample;
      w_cur <= w_eff;
      p_cur <= restart ? '0 : pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      count   <= '0;
      pos     <= '0;
      wrapped <= 1'b0;
    end else if (cmd.accept) begin
      if (restart) begin
        head    <= '0;
        count   <= '0;
        wrapped <= 1'b0;
      end
    end else if (cmd.drop_front) begin
      head  <= head_inc;
      count <= count - CW'(1);
    end else if (cmd.drop_back) begin
      count <= count - CW'(1);
    end else if (cmd.append) begin
      if (full) begin
        head <= head_inc;
      end else begin
        count <= count + CW'(1);
      end
      pos <= p_cur + DATA_W'(1);
      if (p_cur == '1) begin
        wrapped <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_max   <= val_rd;
      out_start <= p_cur - DATA_W'(w_cur - WLEN_W'(1));
    end
  end

  assign results.valid        = out_valid;
  assign results.window_max   = out_max;
  assign results.window_start = out_start;

  assign stat.empty     = (count == '0);
  assign stat.front_old = ((p_cur - pos_rd) >= DATA_W'(w_cur));
  assign stat.back_le   = ($signed(val_rd) <= $signed(samp));
  assign stat.emit      = wrapped || ((33'(p_cur) + 33'd1) >= 33'(w_cur));
  assign stat.out_free  = !out_valid || results.ready;

endmodule

// ===== sv/sliding_window_maximum_core.sv =====
// Sliding window maximum over a stream of signed 32-bit samples.
//
// Channels: samples (sample, restart) in, results (window_max, window_start)
// out, and cfg carrying window_len, all valid/ready; a word moves when both
// are high. cfg is always ready; it is to be written only while the block
// is idle, which the block itself does not enforce. A sample with restart
// set empties the candidate deque and restarts the position count at zero
// before the sample is taken in. Once window_len (clamped to 1..MAX_WINDOW)
// samples have arrived since the last restart (or the position counter has
// wrapped), each sample gives one result word; earlier samples give none.
// Timing: one sample at a time. Once a sample is accepted the controller
// evicts old front candidates, drops back candidates not greater than it,
// appends it, reads the head and loads any result into the output register;
// the next sample can be accepted in the cycle after that. Each deque probe
// is a registered read of the candidate RAM, followed by a compare.
// The next sample is accepted while a result waits in the output register;
// if the receiver still stalls when the next result is due, the block holds
// that item and accepts nothing further.
// Reset clears the controller, the deque pointers, the position counter and
// the output valid, and sets window_len to 1. The candidate RAMs need no
// clearing, as only entries written since the last restart are ever read.
module sliding_window_maximum_core import swm_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic          clk,
  input  logic          rst,
  swm_sample_if.sink    samples,
  swm_result_if.source  results,
  swm_cfg_if.sink       cfg
);

  ctl_cmd_t  cmd;
  ctl_stat_t stat;
  logic      in_ready;

  assign samples.ready = in_ready;

  swm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  swm_dp #(.MAX_WINDOW(MAX_WINDOW)) u_dp (
    .clk     (clk),
    .rst     (rst),
    .sample  (samples.sample),
    .restart (samples.restart),
    .cfg     (cfg),
    .results (results),
    .cmd     (cmd),
    .stat    (stat)
  );

endmodule

// ===== dv/tb_sliding_window_maximum_core.sv =====
// Self-checking testbench for the sliding window maximum core with an in-bench deque predictor.
`timescale 1ns / 100ps

module tb_sliding_window_maximum_core import swm_pkg::*;;

  localparam int          IDX_W          = $clog2(MAX_WINDOW_DEF);
  localparam int unsigned CYCLE_LIMIT    = 800000;
  localparam int unsigned DRAIN_CYCLES   = 2200;
  localparam int unsigned HOLDOFF_CYCLES = 400;
  localparam int unsigned RANDOM_ITEMS   = 240;
  localparam int unsigned MAX_PRINTS     = 40;

  typedef struct packed {
    logic [DATA_W-1:0] peak;
    logic [DATA_W-1:0] first_pos;
  } window_peak_t;

  typedef enum int {RX_STEADY, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_pattern_t;

  logic clk = 1'b0;
  logic rst;

  swm_sample_if sample_ch ();
  swm_result_if result_ch ();
  swm_cfg_if    cfg_ch ();

  sliding_window_maximum_core u_top (
    .clk     (clk),
    .rst     (rst),
    .samples (sample_ch),
    .results (result_ch),
    .cfg     (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: a copy of the candidate deque and the stream counter.
  logic [DATA_W-1:0] dq_val [MAX_WINDOW_DEF];
  logic [DATA_W-1:0] dq_pos [MAX_WINDOW_DEF];
  logic [IDX_W-1:0]  dq_head;
  int unsigned       dq_count;
  logic [DATA_W-1:0] stream_pos;
  bit                pos_wrapped;
  logic [WLEN_W-1:0] len_setting;

  window_peak_t pending_maxima[$];
  int unsigned  mismatch_count;
  int unsigned  cycle_count;
  int unsigned  burst_left;
  bit           idle_sender_en;
  bit           holdoff_req;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
  endtask

  // Advances the deque by one sample; returns 1 when the sample closes a window.
  function automatic bit advance_window(input logic [DATA_W-1:0] raw, input logic rs,
                                        output window_peak_t res);
    int unsigned       w;
    logic [DATA_W-1:0] p;
    logic [DATA_W-1:0] age;
    w = 32'(len_setting);
    if (w == 0) w = 1;
    if (w > MAX_WINDOW_DEF) w = MAX_WINDOW_DEF;
    if (rs) begin
      dq_head     = '0;
      dq_count    = 0;
      stream_pos  = '0;
      pos_wrapped = 1'b0;
    end
    p = stream_pos;
    while (dq_count > 0) begin
      age = p - dq_pos[dq_head];
      if (age < w) break;
      dq_head++;
      dq_count--;
    end
    while (dq_count > 0 &&
           $signed(dq_val[dq_head + IDX_W'(dq_count - 1)]) <= $signed(raw)) begin
      dq_count--;
    end
    if (dq_count >= MAX_WINDOW_DEF) begin
      dq_head++;
      dq_count--;
    end
    dq_val[dq_head + IDX_W'(dq_count)] = raw;
    dq_pos[dq_head + IDX_W'(dq_count)] = p;
    dq_count++;
    stream_pos = p + 1;
    if (stream_pos == '0) pos_wrapped = 1'b1;
    res = '0;
    if (pos_wrapped || ({32'd0, p} + 64'd1) >= 64'(w)) begin
      res.peak      = dq_val[dq_head];
      res.first_pos = p - DATA_W'(w - 1);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [DATA_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom();
      4, 5, 6:    return DATA_W'($urandom_range(0, 8)) - 32'd4;
      7:          return 32'h8000_0000 + DATA_W'($urandom_range(0, 3));
      8:          return 32'h7fff_ffff - DATA_W'($urandom_range(0, 3));
      default:    return DATA_W'($urandom_range(0, 1000));
    endcase
  endfunction

  // Offers one word and waits for it to be taken; idles between bursts when enabled.
  task automatic send_sample(input logic [DATA_W-1:0] value, input logic rs);
    window_peak_t res;
    sample_ch.valid   <= 1'b1;
    sample_ch.sample  <= value;
    sample_ch.restart <= rs;
    do @(posedge clk); while (!sample_ch.ready);
    if (advance_window(value, rs, res)) pending_maxima.insert(pending_maxima.size(), res);
    if (idle_sender_en) begin
      if (burst_left == 0) begin
        sample_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst_left = $urandom_range(1, 24);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic stop_sending();
    sample_ch.valid <= 1'b0;
  endtask

  task automatic wait_for_results();
    stop_sending();
    do @(posedge clk); while (pending_maxima.size() != 0);
  endtask

  // An item that closes no window may still be in the deque logic when the
  // last result has arrived, so allow for its worst-case latency.
  task automatic settle_idle();
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_window_len(input logic [WLEN_W-1:0] len);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.window_len <= len;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    len_setting = len;
  endtask

  task automatic check_window_result(input logic [DATA_W-1:0] got_max,
                                     input logic [DATA_W-1:0] got_start);
    window_peak_t want;
    if (pending_maxima.size() == 0) begin
      report_mismatch($sformatf("unexpected result max=%0d start=%0d",
                                $signed(got_max), got_start));
    end else begin
      want = pending_maxima[0];
      pending_maxima.delete(0);
      if (got_max !== want.peak) begin
        report_mismatch($sformatf("window_max %0d, expected %0d",
                                  $signed(got_max), $signed(want.peak)));
      end
      if (got_start !== want.first_pos) begin
        report_mismatch($sformatf("window_start %0d, expected %0d",
                                  got_start, want.first_pos));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      check_window_result(result_ch.window_max, result_ch.window_start);
    end
  end

  // Receiver: switches between stall patterns and honours a long hold-off on request.
  initial begin
    rx_pattern_t pattern;
    int unsigned pattern_left;
    int unsigned tick;
    pattern      = RX_STEADY;
    pattern_left = 0;
    tick         = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holdoff_req) begin
        result_ch.ready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
        holdoff_req = 1'b0;
      end
      if (pattern_left == 0) begin
        pattern      = rx_pattern_t'($urandom_range(0, 3));
        pattern_left = $urandom_range(40, 300);
      end
      pattern_left--;
      tick++;
      case (pattern)
        RX_STEADY:   result_ch.ready <= 1'b1;
        RX_COIN:     result_ch.ready <= 1'($urandom_range(0, 1));
        RX_PERIODIC: result_ch.ready <= (tick % 4 == 0);
        default:     result_ch.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** sliding_window_maximum_core: FAILED **");
      $finish;
    end
  end

  // Reset leaves a window of one: every word gives its own value back.
  task automatic test_default_window();
    send_sample(32'h0000_0000, 1'b1);
    send_sample(32'h7fff_ffff, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'hffff_ffff, 1'b0);
    send_sample(32'h0000_0001, 1'b0);
  endtask

  // A zero length behaves as a window of one.
  task automatic test_zero_window();
    settle_idle();
    write_window_len('0);
    send_sample(-32'sd3, 1'b0);
    send_sample(32'd9, 1'b0);
    send_sample(32'd2, 1'b1);
  endtask

  // Equal values replace older candidates; restart discards the partial window.
  task automatic test_ties_window();
    settle_idle();
    write_window_len(11'd3);
    send_sample(32'd5, 1'b1);
    send_sample(32'd5, 1'b0);
    send_sample(32'd5, 1'b0);
    send_sample(32'd3, 1'b0);
    send_sample(32'd7, 1'b0);
    send_sample(-32'sd2, 1'b0);
    send_sample(-32'sd2, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'd4, 1'b1);
    send_sample(32'd4, 1'b0);
  endtask

  // The length changes without a restart, first upwards and then downwards.
  task automatic test_window_change();
    settle_idle();
    write_window_len(11'd5);
    send_sample(32'd1, 1'b0);
    send_sample(32'd8, 1'b0);
    send_sample(32'd6, 1'b0);
    settle_idle();
    write_window_len(11'd2);
    send_sample(32'd0, 1'b0);
    send_sample(-32'sd1, 1'b0);
  endtask

  // Long window: a falling run keeps every sample in the window as a
  // candidate while the oldest leaves on each step, then an over-range length
  // is clamped to the store size and holds results back.
  task automatic test_deep_window();
    logic [DATA_W-1:0] v;
    settle_idle();
    write_window_len(11'd200);
    idle_sender_en = 1'b0;
    v = 32'h7fff_ffff;
    send_sample(v, 1'b1);
    for (int i = 1; i < 230; i++) begin
      v = v - DATA_W'($urandom_range(1, 1000));
      send_sample(v, 1'b0);
    end
    idle_sender_en = 1'b1;
    for (int i = 0; i < 10; i++) send_sample(pick_sample(), 1'b0);
    settle_idle();
    write_window_len(11'd2047);
    for (int i = 0; i < 20; i++) send_sample(pick_sample(), 1'b0);
  endtask

  // The receiver holds off long enough for the core to back up its input;
  // later the sender pauses until every result is in.
  task automatic test_result_holdoff();
    settle_idle();
    write_window_len(11'd4);
    idle_sender_en = 1'b0;
    for (int i = 0; i < 80; i++) begin
      if (i == 10) holdoff_req = 1'b1;
      if (i == 50) wait_for_results();
      send_sample(pick_sample(), 1'(i == 0));
    end
  endtask

  task automatic test_random_stream();
    int unsigned       sent;
    int unsigned       phase_len;
    bit                fresh;
    logic [WLEN_W-1:0] len;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0:       len = 11'd1;
        1:       len = 11'd2;
        2:       len = WLEN_W'($urandom_range(3, 8));
        3, 4:    len = WLEN_W'($urandom_range(9, 40));
        default: len = WLEN_W'($urandom_range(41, 100));
      endcase
      settle_idle();
      write_window_len(len);
      idle_sender_en = ($urandom_range(0, 3) != 0);
      fresh          = ($urandom_range(0, 3) != 0);
      phase_len      = $urandom_range(30, 90);
      for (int i = 0; i < phase_len; i++) begin
        send_sample(pick_sample(), 1'((i == 0 && fresh) || $urandom_range(0, 39) == 0));
      end
      sent += phase_len;
    end
  endtask

  initial begin
    int unsigned end_wait;
    mismatch_count   = 0;
    cycle_count      = 0;
    burst_left       = 0;
    idle_sender_en   = 1'b1;
    holdoff_req      = 1'b0;
    dq_head          = '0;
    dq_count         = 0;
    stream_pos       = '0;
    pos_wrapped      = 1'b0;
    len_setting      = 11'd1;
    rst               <= 1'b1;
    sample_ch.valid   <= 1'b0;
    sample_ch.sample  <= '0;
    sample_ch.restart <= 1'b0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.window_len <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_window();
    test_zero_window();
    test_ties_window();
    test_window_change();
    test_deep_window();
    test_result_holdoff();
    test_random_stream();

    stop_sending();
    end_wait = 0;
    while (pending_maxima.size() != 0 && end_wait < CYCLE_LIMIT) begin
      @(posedge clk);
      end_wait++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_maxima.size() != 0) begin
      report_mismatch($sformatf("%0d expected window results never arrived",
                                pending_maxima.size()));
    end
    if (mismatch_count == 0) begin
      $display("** sliding_window_maximum_core: PASSED **");
    end else begin
      $display("** sliding_window_maximum_core: FAILED **");
    end
    $finish;
  end

endmodule
